### design/trace_plot_span_generator_macros.svh
// Assertion macros used by the span generator back end (tpsg_back).
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TRACE_PLOT_SPAN_GENERATOR_MACROS_SVH
`define TRACE_PLOT_SPAN_GENERATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TPSG_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define TPSG_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### design/tpsg_pkg.sv
// Types and constants of the trace plot span generator.
// No dependencies; every other file but the assertion macros imports this package.
package tpsg_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COLOUR_W = 16;
	localparam int PIX_W = 8;
	localparam int CURSOR_W = 7;
	localparam int CFG_INDEX_W = 3;

	localparam int PLOT_TOP_ROW = 32;
	localparam int SCREEN_BOTTOM_ROW = 159;
	localparam int COLUMN_WRAP = 127;
	localparam int ERASE_LENGTH = 128;
	localparam int MAX_SET_COLUMN = 127;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_POINT      = 3'd0,
		OP_LINE       = 3'd1,
		OP_TWO        = 3'd2,
		OP_BAR        = 3'd3,
		OP_STEP       = 3'd4,
		OP_STEP_ERASE = 3'd5,
		OP_SET_X      = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_COLOUR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BAR_COLOUR   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_COLOUR = 3'd4;

	localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RESET = 16'sd0;
	localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RESET = 16'sd4095;
	localparam logic [COLOUR_W-1:0] TRACE_COLOUR_RESET = 16'd63488;
	localparam logic [COLOUR_W-1:0] BAR_COLOUR_RESET = 16'd0;
	localparam logic [COLOUR_W-1:0] ERASE_COLOUR_RESET = 16'd59196;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] range_low;
		logic signed [SAMPLE_W-1:0] range_high;
		logic [COLOUR_W-1:0]        trace_colour;
		logic [COLOUR_W-1:0]        bar_colour;
		logic [COLOUR_W-1:0]        erase_colour;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] diff_a;
		logic [SAMPLE_W-1:0] diff_b;
		logic [SAMPLE_W-1:0] denom;
		logic [CURSOR_W-1:0] x_set;
	} work_t;

	typedef struct packed {
		logic                command_kind;
		logic [PIX_W-1:0]    column;
		logic [PIX_W-1:0]    row_start;
		logic [PIX_W-1:0]    span_length;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} cmd_t;

endpackage

### design/tpsg_if.sv
// Handshake interfaces of the span generator: samples, commands, configuration.
// Depends on tpsg_pkg for field widths.
interface tpsg_sample_if import tpsg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [2:0]                 operation;
	logic signed [SAMPLE_W-1:0] sample_a;
	logic signed [SAMPLE_W-1:0] sample_b;
	logic signed [SAMPLE_W-1:0] x_value;

	modport source(output valid, operation, sample_a, sample_b, x_value, input ready);
	modport sink(input valid, operation, sample_a, sample_b, x_value, output ready);
endinterface

interface tpsg_command_if import tpsg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command_kind;
	logic [PIX_W-1:0]    column;
	logic [PIX_W-1:0]    row_start;
	logic [PIX_W-1:0]    span_length;
	logic [COLOUR_W-1:0] colour;
	logic                last;

	modport source(output valid, command_kind, column, row_start, span_length, colour, last,
		input ready);
	modport sink(input valid, command_kind, column, row_start, span_length, colour, last,
		output ready);
endinterface

interface tpsg_cfg_if import tpsg_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [SAMPLE_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/trace_plot_span_generator.sv
// Top level of the trace plot span generator: configuration registers, front end,
// work queue and back end. Depends on tpsg_pkg, tpsg_if, tpsg_front, tpsg_fifo, tpsg_back.
//
// Channel   Direction  Word
// sample    in         operation, sample_a, sample_b, x_value
// command   out        command_kind, column, row_start, span_length, colour, last
// cfg       in         index, data (register write, always ready)
//
// Step and set x complete in the back end when taken; step erase and clear also emit
// one command. Point, line and bar go through a multiply step, the restoring divider
// (QW = clog2(PLOT_HEIGHT + 1) quotient bits, one bit per cycle), a row step and an emit
// step; two points runs the divider twice. Reset is asynchronous and clears the cursor,
// previous row and queue at once. A stalled command channel holds the back end, while
// the two-entry queue keeps taking sample words until it is full.
module trace_plot_span_generator import tpsg_pkg::*; #(
	parameter int PLOT_HEIGHT = 127
) (
	input  logic           clk,
	input  logic           arst_n,
	tpsg_sample_if.sink    sample,
	tpsg_command_if.source command,
	tpsg_cfg_if.sink       cfg
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	work_t push_item;
	logic  q_valid;
	logic  q_ready;
	work_t q_item;
	logic  cmd_valid;
	cmd_t  cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= RANGE_LOW_RESET;
			cfg_q.range_high <= RANGE_HIGH_RESET;
			cfg_q.trace_colour <= TRACE_COLOUR_RESET;
			cfg_q.bar_colour <= BAR_COLOUR_RESET;
			cfg_q.erase_colour <= ERASE_COLOUR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RANGE_LOW:    cfg_q.range_low <= cfg.data;
				CFG_RANGE_HIGH:   cfg_q.range_high <= cfg.data;
				CFG_TRACE_COLOUR: cfg_q.trace_colour <= cfg.data;
				CFG_BAR_COLOUR:   cfg_q.bar_colour <= cfg.data;
				CFG_ERASE_COLOUR: cfg_q.erase_colour <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	tpsg_front u_front (
		.sample     (sample),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	tpsg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	tpsg_back #(
		.PLOT_HEIGHT (PLOT_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.cmd_valid (cmd_valid),
		.cmd_ready (command.ready),
		.cmd       (cmd)
	);

	assign command.valid = cmd_valid;
	assign command.command_kind = cmd.command_kind;
	assign command.column = cmd.column;
	assign command.row_start = cmd.row_start;
	assign command.span_length = cmd.span_length;
	assign command.colour = cmd.colour;
	assign command.last = cmd.last;

endmodule

### design/tpsg_front.sv
// Front end: takes sample words, clamps them to the plot range and classifies them.
// Depends on tpsg_pkg and tpsg_sample_if; feeds tpsg_fifo.
module tpsg_front import tpsg_pkg::*; (
	tpsg_sample_if.sink sample,
	input  cfg_t        cfg,
	output logic        push_valid,
	input  logic        push_ready,
	output work_t       push_item
);

	logic signed [SAMPLE_W-1:0] top_v;
	logic signed [SAMPLE_W-1:0] bot_v;
	logic signed [SAMPLE_W:0]   span_v;
	logic signed [SAMPLE_W-1:0] xv;

	function automatic logic [SAMPLE_W-1:0] dist_from_top(input logic signed [SAMPLE_W-1:0] y,
		input logic signed [SAMPLE_W-1:0] top, input logic signed [SAMPLE_W-1:0] bot);
		logic signed [SAMPLE_W-1:0] yc;
		logic signed [SAMPLE_W:0]   d;
		yc = y;
		if (y < bot) begin
			yc = bot;
		end
		if (y > top) begin
			yc = top;
		end
		d = {top[SAMPLE_W-1], top} - {yc[SAMPLE_W-1], yc};
		return d[SAMPLE_W-1:0];
	endfunction

	always_comb begin
		top_v = (cfg.range_high > cfg.range_low) ? cfg.range_high : cfg.range_low;
		bot_v = (cfg.range_high > cfg.range_low) ? cfg.range_low : cfg.range_high;
		span_v = {top_v[SAMPLE_W-1], top_v} - {bot_v[SAMPLE_W-1], bot_v};
		xv = sample.x_value;

		push_item.op = op_t'(sample.operation);
		push_item.diff_a = dist_from_top(sample.sample_a, top_v, bot_v);
		push_item.diff_b = dist_from_top(sample.sample_b, top_v, bot_v);
		push_item.denom = span_v[SAMPLE_W-1:0];
		priority if (xv > SAMPLE_W'(MAX_SET_COLUMN)) begin
			push_item.x_set = CURSOR_W'(MAX_SET_COLUMN);
		end else if (xv < 0) begin
			push_item.x_set = '0;
		end else begin
			push_item.x_set = xv[CURSOR_W-1:0];
		end
	end

	assign push_valid = sample.valid;
	assign sample.ready = push_ready;

endmodule

### design/tpsg_fifo.sv
// Short queue of classified work words between the front and back ends.
// Depends on tpsg_pkg for the work word type and the queue depth.
module tpsg_fifo import tpsg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_item
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t            entries_q [QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### design/tpsg_back.sv
// Back end: maps samples to rows with a restoring divider, keeps the cursor and
// previous row, and hands out span and clear commands. Depends on tpsg_pkg and the macros.
`include "trace_plot_span_generator_macros.svh"

module tpsg_back import tpsg_pkg::*; #(
	parameter int PLOT_HEIGHT = 127
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	output logic  q_ready,
	input  work_t q_item,
	output logic  cmd_valid,
	input  logic  cmd_ready,
	output cmd_t  cmd
);

	localparam int QW = $clog2(PLOT_HEIGHT + 1);
	localparam int CW = $clog2(QW);
	localparam int PW = SAMPLE_W + QW;
	localparam int WRAP_STEPS = 128 / COLUMN_WRAP;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_ROW  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t              state_q;
	work_t               item_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic [PIX_W-1:0]    prev_q;
	logic                second_q;
	logic                pair_q;
	logic                emit_idx_q;
	logic [CW-1:0]       cnt_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [QW-1:0]       num_q;
	logic [QW-1:0]       quo_q;
	logic [PIX_W-1:0]    row_a_q;
	cmd_t                cmd0_q;
	cmd_t                cmd1_q;
	logic                out_valid_q;
	cmd_t                out_cmd_q;

	logic [SAMPLE_W-1:0] diff_sel;
	logic [PW-1:0]       prod;
	logic [SAMPLE_W:0]   trial;
	logic [SAMPLE_W:0]   trial_sub;
	logic                qbit;
	logic [PIX_W:0]      row_sum;
	logic [PIX_W-1:0]    row_j;
	logic [PIX_W-1:0]    prev_eff;
	logic [PIX_W-1:0]    line_start;
	logic [PIX_W-1:0]    line_len;
	logic [PIX_W-1:0]    x8;
	logic [PIX_W-1:0]    x8_next;
	logic [PIX_W-1:0]    step_col;
	logic [CURSOR_W-1:0] next_x;
	cmd_t                idle_cmd;
	cmd_t                row_cmd0;
	cmd_t                row_cmd1;
	logic                load_out;

	function automatic cmd_t make_span(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
		input logic [PIX_W-1:0] len, input logic [COLOUR_W-1:0] colour, input logic last);
		cmd_t c;
		c.command_kind = 1'b0;
		c.column = col;
		c.row_start = row;
		c.span_length = len;
		c.colour = colour;
		c.last = last;
		return c;
	endfunction

	assign q_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || cmd_ready);
	assign cmd_valid = out_valid_q;
	assign cmd = out_cmd_q;

	always_comb begin
		diff_sel = second_q ? item_q.diff_b : item_q.diff_a;
		prod = PW'(diff_sel) * PW'(PLOT_HEIGHT);
		trial = {rem_q, num_q[QW-1]};
		trial_sub = trial - {1'b0, item_q.denom};
		qbit = (trial >= {1'b0, item_q.denom});

		row_sum = (PIX_W + 1)'(PLOT_TOP_ROW) + (PIX_W + 1)'(quo_q);
		if (item_q.denom == '0) begin
			row_j = PIX_W'(PLOT_TOP_ROW);
		end else if (row_sum > (PIX_W + 1)'(SCREEN_BOTTOM_ROW)) begin
			row_j = PIX_W'(SCREEN_BOTTOM_ROW);
		end else begin
			row_j = row_sum[PIX_W-1:0];
		end

		if (prev_q < PIX_W'(PLOT_TOP_ROW) || prev_q > PIX_W'(SCREEN_BOTTOM_ROW)) begin
			prev_eff = row_j;
		end else begin
			prev_eff = prev_q;
		end
		priority if (prev_eff < row_j) begin
			line_start = prev_eff + 1'b1;
			line_len = row_j - prev_eff;
		end else if (prev_eff > row_j) begin
			line_start = row_j;
			line_len = prev_eff - row_j;
		end else begin
			line_start = row_j;
			line_len = 8'd1;
		end

		x8 = {1'b0, cursor_q};
		x8_next = x8 + 1'b1;
		step_col = x8_next;
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (step_col >= PIX_W'(COLUMN_WRAP)) begin
				step_col = step_col - PIX_W'(COLUMN_WRAP);
			end
		end
		next_x = step_col[CURSOR_W-1:0];

		if (q_item.op == OP_CLEAR) begin
			idle_cmd = '0;
			idle_cmd.command_kind = 1'b1;
			idle_cmd.last = 1'b1;
		end else begin
			idle_cmd = make_span({1'b0, next_x}, PIX_W'(PLOT_TOP_ROW), PIX_W'(ERASE_LENGTH),
				cfg.erase_colour, 1'b1);
		end

		row_cmd0 = '0;
		row_cmd1 = '0;
		unique case (item_q.op)
			OP_POINT: begin
				row_cmd0 = make_span(x8, row_j, 8'd2, cfg.trace_colour, 1'b0);
				row_cmd1 = make_span(x8_next, row_j, 8'd2, cfg.trace_colour, 1'b1);
			end
			OP_LINE: begin
				row_cmd0 = make_span(x8, line_start, line_len, cfg.trace_colour, 1'b0);
				row_cmd1 = make_span(x8_next, line_start, line_len, cfg.trace_colour, 1'b1);
			end
			OP_TWO: begin
				row_cmd0 = make_span(x8, row_a_q, 8'd1, cfg.trace_colour, 1'b0);
				row_cmd1 = make_span(x8, row_j, 8'd1, cfg.bar_colour, 1'b1);
			end
			OP_BAR: begin
				row_cmd0 = make_span(x8, row_j, PIX_W'(SCREEN_BOTTOM_ROW) - row_j,
					cfg.bar_colour, 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= '0;
			prev_q <= '0;
			second_q <= 1'b0;
			pair_q <= 1'b0;
			emit_idx_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (cmd_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						second_q <= 1'b0;
						pair_q <= 1'b0;
						emit_idx_q <= 1'b0;
						unique case (q_item.op)
							OP_POINT, OP_LINE, OP_TWO, OP_BAR: begin
								state_q <= ST_MUL;
							end
							OP_STEP: begin
								cursor_q <= next_x;
							end
							OP_STEP_ERASE: begin
								cursor_q <= next_x;
								state_q <= ST_EMIT;
							end
							OP_SET_X: begin
								cursor_q <= q_item.x_set;
							end
							OP_CLEAR: begin
								cursor_q <= '0;
								state_q <= ST_EMIT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW - 1)) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (item_q.op == OP_TWO && !second_q) begin
						second_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						emit_idx_q <= 1'b0;
						pair_q <= (item_q.op != OP_BAR);
						if (item_q.op == OP_LINE) begin
							prev_q <= row_j;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						if (emit_idx_q || !pair_q) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			item_q <= q_item;
			cmd0_q <= idle_cmd;
		end
		if (state_q == ST_MUL) begin
			rem_q <= prod[PW-1:QW];
			num_q <= prod[QW-1:0];
		end
		if (state_q == ST_DIV) begin
			rem_q <= qbit ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
		if (state_q == ST_ROW) begin
			if (item_q.op == OP_TWO && !second_q) begin
				row_a_q <= row_j;
			end else begin
				cmd0_q <= row_cmd0;
				cmd1_q <= row_cmd1;
			end
		end
		if (load_out) begin
			out_cmd_q <= emit_idx_q ? cmd1_q : cmd0_q;
		end
	end

	// The divider never leaves its partial remainder at or above the range span.
	`TPSG_ASSERT(a_rem_below_denom, !(state_q == ST_DIV && item_q.denom != '0) || rem_q < item_q.denom, "divider remainder reached the divisor")
	`TPSG_ASSERT(a_quo_in_height, !(state_q == ST_ROW && item_q.denom != '0) || quo_q <= QW'(PLOT_HEIGHT), "row offset exceeds plot height")
	`TPSG_ASSERT_NEXT(a_mul_to_div, state_q == ST_MUL, state_q == ST_DIV && cnt_q == '0, "multiply step not followed by divide")
	`TPSG_ASSERT_NEXT(a_prev_row_valid, state_q == ST_ROW && item_q.op == OP_LINE && !load_out, prev_q >= PIX_W'(PLOT_TOP_ROW) && prev_q <= PIX_W'(SCREEN_BOTTOM_ROW), "line left previous row outside plot")

endmodule
